// ===== src/msd_pkg.sv =====
// msd_pkg: shared types and constants of the mean squared displacement engine
// request and result layouts, configuration register indexes, saturation limits
// no dependencies
`timescale 1ns / 1ps

package msd_pkg;

    localparam logic REQ_SAMPLE = 1'b0;
    localparam logic REQ_READ   = 1'b1;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_EVERY   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_ELEMENTS = 2'd1;

    localparam int SE_W   = 16;
    localparam int BE_W   = 6;
    localparam int CYC_W  = 32;
    localparam int POS_W  = 32;
    localparam int SUM_W  = 63;
    localparam int CNT_W  = 32;
    localparam int LEN_W  = 6;
    localparam int TERM_W = 48;
    localparam int TOT_W  = 50;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [SUM_W-1:0] SUM_MAX = '1;
    localparam logic [CNT_W-1:0] CNT_MAX = '1;
    localparam logic [LEN_W-1:0] LEN_MAX = '1;

    typedef struct packed {
        logic                    req_type;
        logic [1:0]              component_id;
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic signed [POS_W-1:0] pos_z;
        logic                    last_of_frame;
        logic [2:0]              read_block;
        logic [1:0]              read_component;
        logic [4:0]              read_lag;
    } t_item;

    typedef struct packed {
        logic [SUM_W-1:0] sum_x;
        logic [SUM_W-1:0] sum_y;
        logic [SUM_W-1:0] sum_z;
        logic [SUM_W-1:0] sum_total;
        logic [CNT_W-1:0] sample_count;
    } t_acc;

    typedef struct packed {
        t_acc acc;
        logic entry_in_use;
    } t_result;

endpackage

// ===== src/order_n_msd_accumulator_top.sv =====
// order_n_msd_accumulator_top: multiple-tau mean squared displacement engine
// depends on msd_pkg, msd_front, msd_queue and msd_back
//
//   channel   direction   handshake                  payload
//   request   in          i_in_valid / o_in_stall    i_req_type .. i_read_lag
//   result    out         o_out_valid / i_out_stall  o_sum_x .. o_entry_in_use
//   config    in          i_cfg_we                   i_cfg_idx, i_cfg_data
//
// the front checks each sample request against the sampling grid with a divider, then pushes it if on the grid
// the back steps through the S_LRD, S_LDIF, S_LSQ and S_LWR states per lag, block_elements lags
// per active block, per sample; the first sample of a frame adds the activity search, one division per block level
// a read request passes through the S_RD and S_RWAIT states in the back
// after reset the accumulator memory is cleared, one entry per cycle, through all
// MAX_BLOCKS * MAX_COMPONENTS * HISTORY_DEPTH entries while requests are stalled
// a stalled result does not block requests until the two-entry queue fills
`timescale 1ns / 1ps

module order_n_msd_accumulator_top
    import msd_pkg::*;
#(
    parameter int MAX_PARTICLES  = 256,
    parameter int MAX_COMPONENTS = 4,
    parameter int MAX_BLOCKS     = 8,
    parameter int HISTORY_DEPTH  = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic                  i_req_type,
    input  logic [CYC_W-1:0]      i_cycle_number,
    input  logic [1:0]            i_component_id,
    input  logic signed [POS_W-1:0] i_pos_x,
    input  logic signed [POS_W-1:0] i_pos_y,
    input  logic signed [POS_W-1:0] i_pos_z,
    input  logic                  i_last_of_frame,
    input  logic [2:0]            i_read_block,
    input  logic [1:0]            i_read_component,
    input  logic [4:0]            i_read_lag,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [SUM_W-1:0]      o_sum_x,
    output logic [SUM_W-1:0]      o_sum_y,
    output logic [SUM_W-1:0]      o_sum_z,
    output logic [SUM_W-1:0]      o_sum_total,
    output logic [CNT_W-1:0]      o_sample_count,
    output logic                  o_entry_in_use,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int EW = $clog2(HISTORY_DEPTH + 1);

    logic [SE_W-1:0] r_sample_every;
    logic [BE_W-1:0] r_block_elements;
    logic [EW-1:0]   w_elements;
    t_item           w_in_item;
    logic            w_front_stall;
    logic            w_clearing;
    logic            w_q_push;
    t_item           w_q_push_item;
    logic            w_q_pop;
    t_item           w_q_item;
    logic            w_q_full;
    logic            w_q_empty;
    t_result         w_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample_every   <= SE_W'(1);
            r_block_elements <= BE_W'(16);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SAMPLE_EVERY:   r_sample_every   <= i_cfg_data[SE_W-1:0];
                CFG_BLOCK_ELEMENTS: r_block_elements <= i_cfg_data[BE_W-1:0];
                default: ;
            endcase
        end
    end

    assign w_elements = (int'(r_block_elements) < 2) ? EW'(2) :
                        (int'(r_block_elements) > HISTORY_DEPTH) ? EW'(HISTORY_DEPTH) :
                        EW'(r_block_elements);

    assign w_in_item.req_type       = i_req_type;
    assign w_in_item.component_id   = i_component_id;
    assign w_in_item.pos_x          = i_pos_x;
    assign w_in_item.pos_y          = i_pos_y;
    assign w_in_item.pos_z          = i_pos_z;
    assign w_in_item.last_of_frame  = i_last_of_frame;
    assign w_in_item.read_block     = i_read_block;
    assign w_in_item.read_component = i_read_component;
    assign w_in_item.read_lag       = i_read_lag;

    msd_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_in_valid),
        .o_stall       (w_front_stall),
        .i_item        (w_in_item),
        .i_cycle       (i_cycle_number),
        .i_sample_every(r_sample_every),
        .i_hold        (w_clearing),
        .i_q_full      (w_q_full),
        .o_push        (w_q_push),
        .o_push_item   (w_q_push_item)
    );

    msd_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (w_q_push),
        .i_item (w_q_push_item),
        .i_pop  (w_q_pop),
        .o_item (w_q_item),
        .o_full (w_q_full),
        .o_empty(w_q_empty)
    );

    msd_back #(
        .MAX_PARTICLES (MAX_PARTICLES),
        .MAX_COMPONENTS(MAX_COMPONENTS),
        .MAX_BLOCKS    (MAX_BLOCKS),
        .HISTORY_DEPTH (HISTORY_DEPTH),
        .EW            (EW)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_empty  (w_q_empty),
        .i_q_item   (w_q_item),
        .o_pop      (w_q_pop),
        .i_elements (w_elements),
        .i_cfg_wr   (i_cfg_we),
        .o_clearing (w_clearing),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out      (w_out)
    );

    assign o_in_stall     = w_front_stall;
    assign o_sum_x        = w_out.acc.sum_x;
    assign o_sum_y        = w_out.acc.sum_y;
    assign o_sum_z        = w_out.acc.sum_z;
    assign o_sum_total    = w_out.acc.sum_total;
    assign o_sample_count = w_out.acc.sample_count;
    assign o_entry_in_use = w_out.entry_in_use;

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_push |-> !w_q_full || w_q_pop)
        else $error("request queue overflow");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_pop |-> !w_q_empty)
        else $error("pop from empty request queue");

    a_clear_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_clearing |-> o_in_stall)
        else $error("request taken during accumulator clear");

    a_reset_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");
`endif

endmodule

// ===== src/msd_div.sv =====
// msd_div: restoring divider, one quotient bit per cycle
// used for the sample filter and the block activity search; uses no package
`timescale 1ns / 1ps

module msd_div #(
    parameter int NUM_W = 32,
    parameter int DEN_W = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quot,
    output logic [DEN_W-1:0] o_rem
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [NUM_W-1:0] r_q;
    logic [DEN_W-1:0] r_r;
    logic [DEN_W-1:0] r_d;
    logic [DEN_W:0]   w_t;
    logic [DEN_W:0]   w_diff;
    logic             w_ge;

    assign w_t    = {r_r, r_q[NUM_W-1]};
    assign w_ge   = w_t >= {1'b0, r_d};
    assign w_diff = w_t - {1'b0, r_d};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= !i_start && r_busy && (r_cnt == CNT_W'(1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(NUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q <= i_num;
            r_r <= '0;
            r_d <= i_den;
        end else if (r_busy) begin
            r_q <= {r_q[NUM_W-2:0], w_ge};
            r_r <= w_ge ? w_diff[DEN_W-1:0] : w_t[DEN_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;
    assign o_rem  = r_r;

endmodule

// ===== src/msd_front.sv =====
// msd_front: takes requests, drops samples off the sampling grid, queues the rest
// depends on msd_pkg and msd_div
`timescale 1ns / 1ps

module msd_front
    import msd_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  t_item           i_item,
    input  logic [CYC_W-1:0] i_cycle,
    input  logic [SE_W-1:0] i_sample_every,
    input  logic            i_hold,
    input  logic            i_q_full,
    output logic            o_push,
    output t_item           o_push_item
);

    localparam logic [1:0] F_IDLE = 2'd0;
    localparam logic [1:0] F_DIV  = 2'd1;
    localparam logic [1:0] F_PUSH = 2'd2;

    logic [1:0]      r_state;
    t_item           r_item;
    logic            w_acc;
    logic [SE_W-1:0] w_den;
    logic            w_done;
    logic [SE_W-1:0] w_rem;

    assign o_stall = (r_state != F_IDLE) || i_hold;
    assign w_acc   = i_valid && !o_stall;
    assign w_den   = (i_sample_every == '0) ? SE_W'(1) : i_sample_every;

    msd_div #(
        .NUM_W(CYC_W),
        .DEN_W(SE_W)
    ) u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(w_acc && (i_item.req_type == REQ_SAMPLE)),
        .i_num  (i_cycle),
        .i_den  (w_den),
        .o_done (w_done),
        .o_quot (),
        .o_rem  (w_rem)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            case (r_state)
                F_IDLE: begin
                    if (w_acc) begin
                        r_state <= (i_item.req_type == REQ_READ) ? F_PUSH : F_DIV;
                    end
                end
                F_DIV: begin
                    if (w_done) begin
                        r_state <= (w_rem == '0) ? F_PUSH : F_IDLE;
                    end
                end
                F_PUSH: begin
                    if (!i_q_full) begin
                        r_state <= F_IDLE;
                    end
                end
                default: r_state <= F_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_item <= i_item;
        end
    end

    assign o_push      = (r_state == F_PUSH) && !i_q_full;
    assign o_push_item = r_item;

endmodule

// ===== src/msd_queue.sv =====
// msd_queue: short request queue between the front and the back end
// depends on msd_pkg
`timescale 1ns / 1ps

module msd_queue
    import msd_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    input  logic  i_pop,
    output t_item o_item,
    output logic  o_full,
    output logic  o_empty
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_item            r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_cnt;

    assign o_full  = r_cnt == CNT_W'(QUEUE_DEPTH);
    assign o_empty = r_cnt == '0;
    assign o_item  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

endmodule

// ===== src/msd_back.sv =====
// msd_back: block activity search, history shift and lag accumulation, reads
// depends on msd_pkg and msd_div; holds the history and accumulator memories
`timescale 1ns / 1ps

module msd_back
    import msd_pkg::*;
#(
    parameter int MAX_PARTICLES  = 256,
    parameter int MAX_COMPONENTS = 4,
    parameter int MAX_BLOCKS     = 8,
    parameter int HISTORY_DEPTH  = 32,
    parameter int EW             = 6
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_q_empty,
    input  t_item         i_q_item,
    output logic          o_pop,
    input  logic [EW-1:0] i_elements,
    input  logic          i_cfg_wr,
    output logic          o_clearing,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output t_result       o_out
);

    localparam int LW = $clog2(HISTORY_DEPTH);
    localparam int BW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int BCW = $clog2(MAX_BLOCKS + 1);
    localparam int MW = $clog2(MAX_PARTICLES + 1);
    localparam int PW = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;
    localparam int ACC_DEPTH = MAX_BLOCKS * MAX_COMPONENTS * HISTORY_DEPTH;
    localparam int AAW = $clog2(ACC_DEPTH);
    localparam int HIST_DEPTH = MAX_BLOCKS * MAX_PARTICLES * HISTORY_DEPTH;
    localparam int HAW = $clog2(HIST_DEPTH);
    localparam int HW = 3 * POS_W;

    localparam logic [3:0] S_CLR   = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_MGO   = 4'd2;
    localparam logic [3:0] S_MWAIT = 4'd3;
    localparam logic [3:0] S_BLK   = 4'd4;
    localparam logic [3:0] S_LRD   = 4'd5;
    localparam logic [3:0] S_LDIF  = 4'd6;
    localparam logic [3:0] S_LSQ   = 4'd7;
    localparam logic [3:0] S_LWR   = 4'd8;
    localparam logic [3:0] S_FRAME = 4'd9;
    localparam logic [3:0] S_RD    = 4'd10;
    localparam logic [3:0] S_RWAIT = 4'd11;

    function automatic logic [POS_W-1:0] abs_diff(input logic [POS_W-1:0] a,
                                                  input logic [POS_W-1:0] b);
        logic [POS_W:0] d;
        d = {a[POS_W-1], a} - {b[POS_W-1], b};
        return d[POS_W] ? POS_W'(~d + 1'b1) : d[POS_W-1:0];
    endfunction

    function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
                                                 input logic [TOT_W-1:0] b);
        logic [SUM_W:0] s;
        s = {1'b0, a} + (SUM_W + 1)'(b);
        return s[SUM_W] ? SUM_MAX : s[SUM_W-1:0];
    endfunction

    logic [3:0]       r_state;
    t_item            r_item;
    logic [AAW-1:0]   r_clr;
    logic [LEN_W-1:0] r_bl [MAX_BLOCKS];
    logic [CYC_W-1:0] r_frame;
    logic [MW-1:0]    r_mol;
    logic [MAX_BLOCKS-1:0] r_mask;
    logic             r_mask_ok;
    logic [CYC_W-1:0] r_mq;
    logic [BCW-1:0]   r_mb;
    logic [BCW-1:0]   r_b;
    logic [LW-1:0]    r_j;
    logic [EW-1:0]    r_len;
    logic [HW-1:0]    r_hrd;
    t_acc             r_ard;
    logic [POS_W-1:0] r_dx, r_dy, r_dz;
    logic [TERM_W-1:0] r_tx, r_ty, r_tz;
    logic             r_ov;
    t_result          r_out;

    t_acc             m_acc  [ACC_DEPTH];
    logic [HW-1:0]    m_hist [HIST_DEPTH];

    logic             w_div_start;
    logic             w_div_done;
    logic [CYC_W-1:0] w_quot;
    logic [EW-1:0]    w_rem;
    logic             w_mol_ok;
    logic             w_comp_ok;
    logic [BW-1:0]    w_bi;
    logic [LEN_W:0]   w_len1;
    logic [HAW-1:0]   w_hbase;
    logic [HAW-1:0]   w_hra;
    logic [HAW-1:0]   w_hwa;
    logic [HW-1:0]    w_p;
    logic [HW-1:0]    w_old;
    logic [AAW-1:0]   w_lag_addr;
    logic [AAW-1:0]   w_rd_addr;
    logic [AAW-1:0]   w_aaddr;
    logic             w_awe;
    t_acc             w_awd;
    logic             w_upd;
    logic [2*POS_W-1:0] w_sqx, w_sqy, w_sqz;
    logic [TOT_W-1:0] w_tsum;
    logic             w_rd_ok;
    logic [BW-1:0]    w_rbi;
    logic             w_in_use;
    logic             w_out_load;

    assign w_mol_ok  = int'(r_mol) < MAX_PARTICLES;
    assign w_comp_ok = int'(r_item.component_id) < MAX_COMPONENTS;
    assign w_bi      = r_b[BW-1:0];
    assign w_len1    = {1'b0, r_bl[w_bi]} + 1'b1;

    assign w_hbase = HAW'((int'(w_bi) * MAX_PARTICLES + int'(r_mol[PW-1:0])) * HISTORY_DEPTH);
    assign w_hra   = w_hbase + HAW'(r_j) - 1'b1;
    assign w_hwa   = w_hbase + HAW'(r_j);
    assign w_p     = {r_item.pos_x, r_item.pos_y, r_item.pos_z};
    assign w_old   = (r_j == '0) ? w_p : r_hrd;

    assign w_lag_addr = AAW'((int'(w_bi) * MAX_COMPONENTS + int'(r_item.component_id))
                             * HISTORY_DEPTH + int'(r_j));
    assign w_rd_addr  = AAW'((int'(r_item.read_block) * MAX_COMPONENTS
                             + int'(r_item.read_component)) * HISTORY_DEPTH
                             + int'(r_item.read_lag));
    assign w_aaddr = (r_state == S_CLR) ? r_clr :
                     (r_state == S_RD) ? w_rd_addr : w_lag_addr;

    assign w_upd = (int'(r_j) < int'(r_len)) && w_comp_ok;
    assign w_awe = (r_state == S_CLR) || ((r_state == S_LWR) && w_upd);

    assign w_sqx  = r_dx * r_dx;
    assign w_sqy  = r_dy * r_dy;
    assign w_sqz  = r_dz * r_dz;
    assign w_tsum = TOT_W'(r_tx) + TOT_W'(r_ty) + TOT_W'(r_tz);

    always_comb begin
        if (r_state == S_CLR) begin
            w_awd = '0;
        end else begin
            w_awd.sum_x        = sat_add(r_ard.sum_x, TOT_W'(r_tx));
            w_awd.sum_y        = sat_add(r_ard.sum_y, TOT_W'(r_ty));
            w_awd.sum_z        = sat_add(r_ard.sum_z, TOT_W'(r_tz));
            w_awd.sum_total    = sat_add(r_ard.sum_total, w_tsum);
            w_awd.sample_count = (r_ard.sample_count == CNT_MAX) ?
                                 CNT_MAX : r_ard.sample_count + 1'b1;
        end
    end

    assign w_rd_ok = (int'(r_item.read_block) < MAX_BLOCKS)
                  && (int'(r_item.read_component) < MAX_COMPONENTS)
                  && (int'(r_item.read_lag) < HISTORY_DEPTH);
    assign w_rbi    = BW'(r_item.read_block);
    assign w_in_use = (int'(r_item.read_lag) < int'(r_bl[w_rbi]))
                   && (int'(r_item.read_lag) < int'(i_elements));
    assign w_out_load = (r_state == S_RWAIT) && (!r_ov || !i_out_stall);

    assign w_div_start = (r_state == S_MGO) && (int'(r_mb) < MAX_BLOCKS);

    msd_div #(
        .NUM_W(CYC_W),
        .DEN_W(EW)
    ) u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(w_div_start),
        .i_num  (r_mq),
        .i_den  (i_elements),
        .o_done (w_div_done),
        .o_quot (w_quot),
        .o_rem  (w_rem)
    );

    assign o_pop = (r_state == S_IDLE) && !i_q_empty;

    // memories
    always_ff @(posedge i_clk) begin
        if (w_awe) begin
            m_acc[w_aaddr] <= w_awd;
        end
        if ((r_state == S_LRD) || (r_state == S_RD)) begin
            r_ard <= m_acc[w_aaddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_LWR) begin
            m_hist[w_hwa] <= w_old;
        end
        if ((r_state == S_LRD) && (r_j != '0)) begin
            r_hrd <= m_hist[w_hra];
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_item <= i_q_item;
        end
        if (r_state == S_LDIF) begin
            r_dx <= abs_diff(w_old[HW-1 -: POS_W], w_p[HW-1 -: POS_W]);
            r_dy <= abs_diff(w_old[2*POS_W-1 -: POS_W], w_p[2*POS_W-1 -: POS_W]);
            r_dz <= abs_diff(w_old[POS_W-1:0], w_p[POS_W-1:0]);
        end
        if (r_state == S_LSQ) begin
            r_tx <= w_sqx[2*POS_W-1:16];
            r_ty <= w_sqy[2*POS_W-1:16];
            r_tz <= w_sqz[2*POS_W-1:16];
        end
        if (w_out_load) begin
            r_out.acc          <= w_rd_ok ? r_ard : '0;
            r_out.entry_in_use <= w_rd_ok && w_in_use;
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLR;
            r_clr     <= '0;
            r_frame   <= '0;
            r_mol     <= '0;
            r_mask    <= '0;
            r_mask_ok <= 1'b0;
            r_mq      <= '0;
            r_mb      <= '0;
            r_b       <= '0;
            r_j       <= '0;
            r_len     <= '0;
            r_ov      <= 1'b0;
            for (int i = 0; i < MAX_BLOCKS; i++) begin
                r_bl[i] <= '0;
            end
        end else begin
            if (w_out_load) begin
                r_ov <= 1'b1;
            end else if (r_ov && !i_out_stall) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                S_CLR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == AAW'(ACC_DEPTH - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_cfg_wr) begin
                        r_mask_ok <= 1'b0;
                    end
                    if (!i_q_empty) begin
                        r_b <= '0;
                        if (i_q_item.req_type == REQ_READ) begin
                            r_state <= S_RD;
                        end else if (r_mask_ok) begin
                            r_state <= w_mol_ok ? S_BLK : S_FRAME;
                        end else begin
                            r_mq    <= r_frame;
                            r_mb    <= BCW'(1);
                            r_mask  <= MAX_BLOCKS'(1);
                            r_state <= S_MGO;
                        end
                    end
                end
                S_MGO: begin
                    if (int'(r_mb) < MAX_BLOCKS) begin
                        r_state <= S_MWAIT;
                    end else begin
                        r_mask_ok <= 1'b1;
                        r_state   <= w_mol_ok ? S_BLK : S_FRAME;
                    end
                end
                S_MWAIT: begin
                    if (w_div_done) begin
                        if ((w_rem == '0) && (w_quot != '0)) begin
                            r_mask[r_mb[BW-1:0]] <= 1'b1;
                            r_mq    <= w_quot;
                            r_mb    <= r_mb + 1'b1;
                            r_state <= S_MGO;
                        end else begin
                            r_mask_ok <= 1'b1;
                            r_state   <= w_mol_ok ? S_BLK : S_FRAME;
                        end
                    end
                end
                S_BLK: begin
                    if (r_b == BCW'(MAX_BLOCKS)) begin
                        r_state <= S_FRAME;
                    end else if (r_mask[w_bi]) begin
                        r_len   <= (int'(w_len1) > int'(i_elements)) ?
                                   i_elements : EW'(w_len1);
                        r_j     <= LW'(i_elements - 1'b1);
                        r_state <= S_LRD;
                    end else begin
                        r_b <= r_b + 1'b1;
                    end
                end
                S_LRD:  r_state <= S_LDIF;
                S_LDIF: r_state <= S_LSQ;
                S_LSQ:  r_state <= S_LWR;
                S_LWR: begin
                    if (r_j == '0) begin
                        r_b     <= r_b + 1'b1;
                        r_state <= S_BLK;
                    end else begin
                        r_j     <= r_j - 1'b1;
                        r_state <= S_LRD;
                    end
                end
                S_FRAME: begin
                    if (r_item.last_of_frame) begin
                        for (int i = 0; i < MAX_BLOCKS; i++) begin
                            if (r_mask[i] && (r_bl[i] != LEN_MAX)) begin
                                r_bl[i] <= r_bl[i] + 1'b1;
                            end
                        end
                        r_frame   <= r_frame + 1'b1;
                        r_mol     <= '0;
                        r_mask_ok <= 1'b0;
                    end else if (w_mol_ok) begin
                        r_mol <= r_mol + 1'b1;
                    end
                    r_state <= S_IDLE;
                end
                S_RD: r_state <= S_RWAIT;
                S_RWAIT: begin
                    if (w_out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_clearing  = r_state == S_CLR;
    assign o_out_valid = r_ov;
    assign o_out       = r_out;

endmodule

// ===== test/testbench.sv =====
// testbench: self-checking bench for order_n_msd_accumulator_top
// drives sample and read requests, predicts every read from its own msd model
// depends on msd_pkg and the rtl of order_n_msd_accumulator_top
`timescale 1ns / 1ps

module testbench;
    import msd_pkg::*;

    localparam int N_BLK = 8;
    localparam int N_CMP = 4;
    localparam int N_MOL = 256;
    localparam int H_DEP = 32;
    localparam int MOLS_PER_FRAME = 3;
    localparam int DRAIN_CYCLES = 5000;
    localparam int CYCLE_LIMIT = 10000000;
    localparam logic [SUM_W-1:0] SUM_LIMIT = SUM_MAX;

    typedef struct {
        logic        kind;
        logic [31:0] cycle;
        logic [1:0]  comp;
        logic [31:0] px, py, pz;
        logic        last;
        logic [2:0]  rblk;
        logic [1:0]  rcmp;
        logic [4:0]  rlag;
    } t_msd_req;

    typedef struct {
        logic [62:0] sx, sy, sz, st;
        logic [31:0] cnt;
        logic        in_use;
    } t_msd_entry;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_stall;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    logic [SUM_W-1:0] o_sum_x, o_sum_y, o_sum_z, o_sum_total;
    logic [CNT_W-1:0] o_sample_count;
    logic o_entry_in_use;
    logic i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    t_msd_req cur_req = '{default: '0};
    t_msd_req pending_reqs[$];
    t_msd_entry expected_entries[$];
    bit req_taken = 1'b0;
    bit calm = 1'b0;
    bit failed = 1'b0;
    int in_gap = 0;
    int out_gap = 0;
    int cycle_cnt = 0;

    // model state
    bit [15:0] m_sample_every = 16'd1;
    bit [5:0]  m_elements = 6'd16;
    bit [31:0] m_frames = '0;
    int        m_mol = 0;
    int        m_len[N_BLK];
    bit [95:0] m_hist[N_BLK][N_MOL][H_DEP];
    bit [62:0] m_sums[N_BLK][N_CMP][H_DEP][4];
    bit [31:0] m_cnts[N_BLK][N_CMP][H_DEP];

    // generator state
    bit [31:0] last_pos[MOLS_PER_FRAME][3];
    bit [15:0] gen_se = 16'd1;

    always #1 i_clk = ~i_clk;

    order_n_msd_accumulator_top u_top (
        .i_clk, .i_rst_n, .i_in_valid, .o_in_stall,
        .i_req_type(cur_req.kind), .i_cycle_number(cur_req.cycle),
        .i_component_id(cur_req.comp), .i_pos_x(cur_req.px), .i_pos_y(cur_req.py),
        .i_pos_z(cur_req.pz), .i_last_of_frame(cur_req.last),
        .i_read_block(cur_req.rblk), .i_read_component(cur_req.rcmp),
        .i_read_lag(cur_req.rlag),
        .o_out_valid, .i_out_stall, .o_sum_x, .o_sum_y, .o_sum_z, .o_sum_total,
        .o_sample_count, .o_entry_in_use, .i_cfg_we, .i_cfg_idx, .i_cfg_data
    );

    function automatic int eff_elements();
        int e;
        e = m_elements;
        if (e < 2) e = 2;
        if (e > H_DEP) e = H_DEP;
        return e;
    endfunction

    function automatic bit [63:0] sq_term(bit [31:0] a, bit [31:0] b);
        longint d;
        bit [63:0] m;
        d = longint'($signed(a)) - longint'($signed(b));
        m = (d < 0) ? -d : d;
        return (m * m) >> 16;
    endfunction

    function automatic bit [62:0] sat_add(bit [62:0] a, bit [63:0] b);
        bit [63:0] s;
        s = {1'b0, a} + b;
        return (s > {1'b0, SUM_LIMIT}) ? SUM_LIMIT : s[62:0];
    endfunction

    function automatic bit [7:0] active_blocks(int e);
        int nb;
        bit [31:0] k, q;
        bit act;
        bit [7:0] mask;
        nb = 1;
        k = m_frames / e;
        q = m_frames;
        act = 1'b1;
        mask = 8'd1;
        while (k != 0) begin
            nb++;
            k = k / e;
        end
        for (int b = 1; b < nb && b < N_BLK; b++) begin
            act = act && (q % e == 0);
            q = q / e;
            if (act) mask[b] = 1'b1;
        end
        return mask;
    endfunction

    // apply one request to the model, returns 1 when a read result is due
    function automatic bit msd_model_step(t_msd_req r, output t_msd_entry res);
        int e, len;
        bit [15:0] se;
        bit [7:0] mask;
        bit [95:0] p, h;
        bit [63:0] tx, ty, tz;
        e = eff_elements();
        res = '{default: '0};
        if (r.kind == REQ_READ) begin
            len = (m_len[r.rblk] < e) ? m_len[r.rblk] : e;
            res.sx = m_sums[r.rblk][r.rcmp][r.rlag][0];
            res.sy = m_sums[r.rblk][r.rcmp][r.rlag][1];
            res.sz = m_sums[r.rblk][r.rcmp][r.rlag][2];
            res.st = m_sums[r.rblk][r.rcmp][r.rlag][3];
            res.cnt = m_cnts[r.rblk][r.rcmp][r.rlag];
            res.in_use = (r.rlag < len);
            return 1'b1;
        end
        se = (m_sample_every == 0) ? 16'd1 : m_sample_every;
        if (r.cycle % se != 0) return 1'b0;
        mask = active_blocks(e);
        if (m_mol < N_MOL) begin
            p = {r.px, r.py, r.pz};
            for (int b = 0; b < N_BLK; b++) begin
                if (!mask[b]) continue;
                for (int j = e - 1; j >= 1; j--) m_hist[b][m_mol][j] = m_hist[b][m_mol][j-1];
                m_hist[b][m_mol][0] = p;
                len = m_len[b] + 1;
                if (len > e) len = e;
                for (int j = 0; j < len; j++) begin
                    h = m_hist[b][m_mol][j];
                    tx = sq_term(h[95:64], p[95:64]);
                    ty = sq_term(h[63:32], p[63:32]);
                    tz = sq_term(h[31:0], p[31:0]);
                    if (m_cnts[b][r.comp][j] != CNT_MAX) m_cnts[b][r.comp][j]++;
                    m_sums[b][r.comp][j][0] = sat_add(m_sums[b][r.comp][j][0], tx);
                    m_sums[b][r.comp][j][1] = sat_add(m_sums[b][r.comp][j][1], ty);
                    m_sums[b][r.comp][j][2] = sat_add(m_sums[b][r.comp][j][2], tz);
                    m_sums[b][r.comp][j][3] = sat_add(m_sums[b][r.comp][j][3], tx + ty + tz);
                end
            end
            m_mol++;
        end
        if (r.last) begin
            for (int b = 0; b < N_BLK; b++)
                if (mask[b] && m_len[b] < LEN_MAX) m_len[b]++;
            m_frames++;
            m_mol = 0;
        end
        return 1'b0;
    endfunction

    // driver
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!i_in_valid || req_taken) begin
                if (in_gap > 0) begin
                    in_gap <= in_gap - 1;
                    i_in_valid <= 1'b0;
                end else if (pending_reqs.size() > 0 && !calm && $urandom_range(0, 7) == 0) begin
                    in_gap <= $urandom_range(0, 18);
                    i_in_valid <= 1'b0;
                end else if (pending_reqs.size() > 0) begin
                    cur_req = pending_reqs.pop_front();
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
            if (out_gap > 0) begin
                out_gap <= out_gap - 1;
                i_out_stall <= 1'b1;
            end else if (!calm && $urandom_range(0, 15) == 0) begin
                out_gap <= $urandom_range(0, 18);
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_msd_entry res, exp_res;
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
        req_taken <= i_rst_n && i_in_valid && !o_in_stall;
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            if (msd_model_step(cur_req, res)) expected_entries.push_back(res);
        end
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_entries.size() == 0) begin
                $display("%0t: result with no read pending", $time);
                failed = 1'b1;
            end else begin
                exp_res = expected_entries.pop_front();
                if (o_sum_x !== exp_res.sx) begin
                    $display("%0t: sum_x exp %h got %h", $time, exp_res.sx, o_sum_x);
                    failed = 1'b1;
                end
                if (o_sum_y !== exp_res.sy) begin
                    $display("%0t: sum_y exp %h got %h", $time, exp_res.sy, o_sum_y);
                    failed = 1'b1;
                end
                if (o_sum_z !== exp_res.sz) begin
                    $display("%0t: sum_z exp %h got %h", $time, exp_res.sz, o_sum_z);
                    failed = 1'b1;
                end
                if (o_sum_total !== exp_res.st) begin
                    $display("%0t: sum_total exp %h got %h", $time, exp_res.st, o_sum_total);
                    failed = 1'b1;
                end
                if (o_sample_count !== exp_res.cnt) begin
                    $display("%0t: sample_count exp %h got %h", $time, exp_res.cnt,
                             o_sample_count);
                    failed = 1'b1;
                end
                if (o_entry_in_use !== exp_res.in_use) begin
                    $display("%0t: entry_in_use exp %b got %b", $time, exp_res.in_use,
                             o_entry_in_use);
                    failed = 1'b1;
                end
            end
        end
    end

    function automatic bit [31:0] sampled_cycle();
        if (gen_se == 1) return $urandom;
        return gen_se * $urandom_range(0, 32'hFFFF_FFFF / gen_se);
    endfunction

    task automatic push_sample(bit [1:0] comp, bit [31:0] x, bit [31:0] y, bit [31:0] z,
                               bit last);
        t_msd_req r;
        r = '{default: '0};
        r.kind = REQ_SAMPLE;
        r.cycle = sampled_cycle();
        r.comp = comp;
        r.px = x;
        r.py = y;
        r.pz = z;
        r.last = last;
        r.rblk = $urandom;
        r.rcmp = $urandom;
        r.rlag = $urandom;
        pending_reqs.push_back(r);
    endtask

    task automatic push_read(bit [2:0] blk, bit [1:0] cmp, bit [4:0] lag);
        t_msd_req r;
        r = '{default: '0};
        r.kind = REQ_READ;
        r.cycle = $urandom;
        r.comp = $urandom;
        r.px = $urandom;
        r.py = $urandom;
        r.pz = $urandom;
        r.last = $urandom;
        r.rblk = blk;
        r.rcmp = cmp;
        r.rlag = lag;
        pending_reqs.push_back(r);
    endtask

    // unsampled request, ignored by the block
    task automatic push_offgrid();
        t_msd_req r;
        r = '{default: '0};
        r.kind = REQ_SAMPLE;
        r.cycle = gen_se * $urandom_range(0, 32'hFFFF_FFFF / gen_se - 1)
                  + $urandom_range(1, gen_se - 1);
        r.comp = $urandom;
        r.px = $urandom;
        r.py = $urandom;
        r.pz = $urandom;
        r.last = $urandom;
        pending_reqs.push_back(r);
    endtask

    function automatic bit [31:0] next_coord(bit [31:0] prev);
        if ($urandom_range(0, 7) == 0) return $urandom;
        return prev + $urandom_range(0, 1 << 20) - (1 << 19);
    endfunction

    task automatic push_frames(int n);
        for (int f = 0; f < n; f++) begin
            for (int m = 0; m < MOLS_PER_FRAME; m++) begin
                for (int a = 0; a < 3; a++) last_pos[m][a] = next_coord(last_pos[m][a]);
                if (gen_se > 1 && $urandom_range(0, 5) == 0) push_offgrid();
                push_sample($urandom, last_pos[m][0], last_pos[m][1], last_pos[m][2],
                            m == MOLS_PER_FRAME - 1);
                if ($urandom_range(0, 2) == 0)
                    push_read($urandom_range(0, 9) < 7 ? $urandom_range(0, 3) : $urandom_range(4, 7),
                              $urandom, $urandom);
            end
        end
    endtask

    task automatic settle();
        wait (pending_reqs.size() == 0 && expected_entries.size() == 0 && !i_in_valid);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_idx = idx;
        i_cfg_data = data;
        if (idx == CFG_SAMPLE_EVERY) m_sample_every = data;
        else if (idx == CFG_BLOCK_ELEMENTS) m_elements = data[5:0];
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    initial begin
        for (int b = 0; b < N_BLK; b++) m_len[b] = 0;
        for (int m = 0; m < MOLS_PER_FRAME; m++)
            for (int a = 0; a < 3; a++) last_pos[m][a] = $urandom;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // first frame overflows the molecule table, history starts fresh
        push_sample(2'd0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 1'b0);
        push_sample(2'd3, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF, 1'b0);
        push_sample(2'd1, 32'h0, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
        for (int m = 3; m < N_MOL + 2; m++)
            push_sample($urandom, $urandom, $urandom, $urandom, m == N_MOL + 1);
        push_read(3'd0, 2'd0, 5'd0);
        push_sample(2'd0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
        push_sample(2'd3, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
        push_sample(2'd2, 32'h0, 32'h0, 32'h0, 1'b1);
        push_read(3'd0, 2'd0, 5'd1);
        push_read(3'd0, 2'd3, 5'd1);
        push_read(3'd0, 2'd2, 5'd0);
        push_read(3'd0, 2'd1, 5'd0);
        push_read(3'd7, 2'd3, 5'd31);
        push_read(3'd0, 2'd0, 5'd31);
        for (int m = 0; m < MOLS_PER_FRAME; m++) begin
            last_pos[m][0] = 32'h0;
            last_pos[m][1] = 32'h0;
            last_pos[m][2] = 32'h0;
        end
        settle();

        write_reg(CFG_BLOCK_ELEMENTS, 16'd32);
        write_reg(CFG_SAMPLE_EVERY, 16'd1);
        gen_se = 16'd1;
        push_frames(60);
        settle();

        write_reg(CFG_BLOCK_ELEMENTS, 16'd5);
        write_reg(CFG_SAMPLE_EVERY, 16'd65535);
        gen_se = 16'd65535;
        push_frames(50);
        settle();

        write_reg(CFG_BLOCK_ELEMENTS, 16'd2);
        write_reg(CFG_SAMPLE_EVERY, 16'd7);
        gen_se = 16'd7;
        push_frames(100);
        settle();

        // below the legal depth, clamps to two
        write_reg(CFG_BLOCK_ELEMENTS, 16'd1);
        write_reg(CFG_SAMPLE_EVERY, 16'd1);
        gen_se = 16'd1;
        calm = 1'b1;
        push_frames(25);
        for (int b = 0; b < N_BLK; b++) push_read(b, $urandom, 5'd1);
        settle();

        if (failed)
            $display("Test completed with failures");
        else
            $display("Test completed successfully");
        $finish;
    end

endmodule
